[rtl/fnvhv_pkg.sv]
package fnvhv_pkg;

    localparam int unsigned HeaderBytes = 8;
    localparam int unsigned HashWidth   = 64;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned CountWidth  = 4;

    localparam logic [HashWidth-1:0] FnvBasis = 64'hcbf2_9ce4_8422_2325;
    localparam logic [HashWidth-1:0] FnvPrime = 64'h0000_0100_0000_01b3;

    typedef enum logic [1:0] {
        StValid    = 2'd0,
        StShort    = 2'd1,
        StMismatch = 2'd2
    } status_t;

    // x * FnvPrime mod 2^64, prime = 2^40 + 2^8 + 0xb3, 0xb3 = bits 7,5,4,1,0
    function automatic logic [HashWidth-1:0] fnv_mult(input logic [HashWidth-1:0] x);
        logic [HashWidth-1:0] prod;
        prod = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
        return prod;
    endfunction

endpackage

[rtl/fnv1a_checksum_header_verify.sv]
// an accepted word passes the input register and then the result register on its way to out_valid
// throughput: one word per cycle, with out_ready held high
// header words (the first eight of a record) give no result unless one is the last
// the hash step is a constant shift-add multiply, done in the cycle between the registers
// reset (rst_n low, asynchronous) empties both stages and restores the fnv offset basis
module fnv1a_checksum_header_verify
    import fnvhv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ByteWidth-1:0] data_byte,
    input  logic                 is_last,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ByteWidth-1:0] payload_byte,
    output logic                 payload_valid,
    output logic                 record_end,
    output logic [1:0]           status,
    output logic [HashWidth-1:0] hash_value
);

    // input register stage
    logic                 s1_valid_reg;
    logic [ByteWidth-1:0] s1_byte_reg;
    logic                 s1_last_reg;

    // record state
    logic [HashWidth-1:0]  expected_reg;
    logic [HashWidth-1:0]  expected_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic [HashWidth-1:0]  hash_reg;
    logic [HashWidth-1:0]  hash_next;

    // result register
    logic                 out_valid_reg;
    logic [ByteWidth-1:0] out_byte_reg;
    logic                 out_pay_reg;
    logic                 out_end_reg;
    status_t              out_status_reg;
    logic [HashWidth-1:0] out_hash_reg;

    logic                 is_payload;
    logic                 emit;
    logic                 s1_fire;
    logic [HashWidth-1:0] hash_step;
    logic [HashWidth-1:0] hash_out;
    status_t              status_calc;

    // header complete once the count has reached eight
    assign is_payload = count_reg[CountWidth-1];
    assign emit       = is_payload || s1_last_reg;

    // a header word with nothing to report retires even while the result waits
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready || !emit);
    assign in_ready = !s1_valid_reg || s1_fire;

    // one fnv-1a step: xor the byte in, then multiply by the prime
    assign hash_step = fnv_mult(hash_reg ^ {{(HashWidth-ByteWidth){1'b0}}, s1_byte_reg});
    assign hash_out  = is_payload ? hash_step : hash_reg;

    always_comb
    begin
        expected_next = expected_reg;
        count_next    = count_reg;
        if (!is_payload)
        begin
            // little-endian header: byte i lands in bits 8i+7..8i
            expected_next[{count_reg[2:0], 3'b000} +: ByteWidth] = s1_byte_reg;
            count_next = count_reg + CountWidth'(1);
        end
    end

    always_comb
    begin
        if (!count_next[CountWidth-1])
        begin
            status_calc = StShort;
        end
        else if (expected_next != hash_out)
        begin
            status_calc = StMismatch;
        end
        else
        begin
            status_calc = StValid;
        end
        if (!s1_last_reg)
        begin
            status_calc = StValid;
        end
    end

    assign hash_next = hash_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= is_last;
        end
    end

    // record state, back to the reset values after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            count_reg    <= '0;
            hash_reg     <= FnvBasis;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                expected_reg <= '0;
                count_reg    <= '0;
                hash_reg     <= FnvBasis;
            end
            else
            begin
                expected_reg <= expected_next;
                count_reg    <= count_next;
                hash_reg     <= hash_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && emit)
        begin
            out_byte_reg   <= is_payload ? s1_byte_reg : '0;
            out_pay_reg    <= is_payload;
            out_end_reg    <= s1_last_reg;
            out_status_reg <= status_calc;
            out_hash_reg   <= hash_out;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = out_byte_reg;
    assign payload_valid = out_pay_reg;
    assign record_end    = out_end_reg;
    assign status        = out_status_reg;
    assign hash_value    = out_hash_reg;

endmodule

[rtl/fnvhv_checker.sv]
module fnvhv_checker
    import fnvhv_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [ByteWidth-1:0] data_byte,
    input logic                 is_last,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [ByteWidth-1:0] payload_byte,
    input logic                 payload_valid,
    input logic                 record_end,
    input logic [1:0]           status,
    input logic [HashWidth-1:0] hash_value
);

    // offered word holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(is_last))
        else $error("input word changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hash_value) && $stable(status))
        else $error("result changed while stalled");

    // a result without a payload word only reports a record end
    a_nopay_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> record_end && payload_byte == '0)
        else $error("empty result without record end");

    // status is only reported at record end
    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !record_end |-> status == StValid)
        else $error("status outside record end");

    // a short record has seen no payload
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == StShort |-> !payload_valid && hash_value == FnvBasis)
        else $error("short record with payload or hash");

endmodule

bind fnv1a_checksum_header_verify fnvhv_checker u_fnvhv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .record_end    (record_end),
    .status        (status),
    .hash_value    (hash_value)
);
